// ----- rtl/core/text_console_cursor_scroll_defines.svh -----
// Assertion macros for the text console engine.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

`ifndef SYNTH

// Property that must hold in the same cycle as its antecedent.
`define TCCS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("text console assertion failed");

// Property that must hold in the cycle after its antecedent.
`define TCCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("text console assertion failed");

`else

`define TCCS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define TCCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/core/tccs_pkg.sv -----
// Types and constants shared by the text console engine.
package tccs_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(CELL_COUNT);

  // Field widths fixed by the interface.
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Derived address and cursor constants.
  localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] CELL_LAST    = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END   = ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ROW_OFF = ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
  localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(SCREEN_HEIGHT - 1);

  // Character codes and limits.
  localparam logic [7:0]       CH_NEWLINE    = 8'd10;
  localparam logic [7:0]       CH_RETURN     = 8'd13;
  localparam logic [7:0]       CH_BLANK      = 8'h20;
  localparam logic [7:0]       ATTR_RESET    = 8'h0F;
  localparam logic [COL_W-1:0] BS_MIN_COL    = COL_W'(2);

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_TEXT_ATTRIBUTE = 1'b0
  } reg_idx_e;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_BACK  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       char_code;
    logic [7:0]       typed_count;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } in_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_value;
  } out_beat_t;

endpackage

// ----- rtl/core/text_console_cursor_scroll.sv -----
// Text console engine: screen store, cursor, scroll and clear sequencer.
//
//  Channel  | Direction | Handshake            | Beat
//  ---------+-----------+----------------------+---------------------------
//  in       | sink      | in_valid_i/in_stall_o | in_beat_t command
//  out      | source    | out_valid_o/out_stall_i | out_beat_t cursor report
//  cfg      | APB slave | psel/penable/pready  | text_attribute at 0x0
//
// A put, carriage return, plain newline, backspace or off-screen read sets out_valid_q
// directly on acceptance, and an on-screen read first passes through rdata_q and ST_READ.
// A scroll adds a copy pass over all rows but the last and a fill of the last row, and a
// clear adds a fill of the whole store, at most one store write per cycle via one write port.
// After reset a clearing pass blanks the store; no beat is taken meanwhile.
// One command is in flight at a time; a new one is taken once the previous report has left.
`include "text_console_cursor_scroll_defines.svh"

module text_console_cursor_scroll (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tccs_pkg::in_beat_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tccs_pkg::out_beat_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tccs_pkg::PADDR_W-1:0]      paddr,
  input  logic [tccs_pkg::PDATA_W-1:0]      pwdata,
  output logic [tccs_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import tccs_pkg::*;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   ptr_q, ptr_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ADDR_W-1:0]   off_q, off_d;
  logic [CELL_W-1:0]   cell_q, cell_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          attr_q;

  logic [CELL_W-1:0]   screen_q [CELL_COUNT];
  logic [CELL_W-1:0]   rdata_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  logic                in_acc;
  logic                cfg_wr;
  logic                newline;
  logic                read_ok;
  logic [ADDR_W-1:0]   read_addr;
  logic [CELL_W-1:0]   blank;

  // Handshakes.
  assign in_stall_o = (state_q != ST_IDLE) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;

  // Configuration register and read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_wr && (reg_idx_e'(paddr[PADDR_W-1]) == REG_TEXT_ATTRIBUTE)) begin
      attr_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx_e'(paddr[PADDR_W-1]) == REG_TEXT_ATTRIBUTE) begin
      prdata = {{(PDATA_W-8){1'b0}}, attr_q};
    end
  end

  assign blank = {attr_q, CH_BLANK};

  // Address of the cell asked for by a read command.
  assign read_ok   = (int'(in_data_i.read_row) < SCREEN_HEIGHT) &&
                     (int'(in_data_i.read_col) < SCREEN_WIDTH);
  assign read_addr = ADDR_W'(int'(in_data_i.read_row) * SCREEN_WIDTH +
                             int'(in_data_i.read_col));

  // Screen store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= screen_q[mem_raddr];
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      row_q       <= row_d;
      col_q       <= col_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  // Next state, cursor update and store port control.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    row_d       = row_q;
    col_d       = col_q;
    off_d       = off_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = blank;
    mem_raddr   = '0;
    newline     = 1'b0;

    case (state_q)
      // Blank the whole store with the reset attribute.
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {ATTR_RESET, CH_BLANK};
        if (ptr_q == CELL_LAST) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          cell_d = '0;
          case (mode_e'(in_data_i.mode))
            MODE_PUT: begin
              if (in_data_i.char_code == CH_NEWLINE) begin
                newline = 1'b1;
              end else if (in_data_i.char_code == CH_RETURN) begin
                col_d       = '0;
                off_d       = off_q - ADDR_W'(col_q);
                out_valid_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = off_q;
                mem_wdata = {attr_q, in_data_i.char_code};
                if (col_q == COL_LAST) begin
                  newline = 1'b1;
                end else begin
                  col_d       = col_q + 1'b1;
                  off_d       = off_q + 1'b1;
                  out_valid_d = 1'b1;
                end
              end
            end
            MODE_BACK: begin
              if ((in_data_i.typed_count != '0) && (col_q > BS_MIN_COL)) begin
                col_d     = col_q - 1'b1;
                off_d     = off_q - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = off_q - 1'b1;
                mem_wdata = blank;
              end
              out_valid_d = 1'b1;
            end
            MODE_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              off_d   = '0;
              ptr_d   = '0;
              state_d = ST_FILL;
            end
            MODE_READ: begin
              if (read_ok) begin
                mem_raddr = read_addr;
                state_d   = ST_READ;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase

          // Move to the start of the next row, scrolling from the last one.
          if (newline) begin
            col_d = '0;
            if (row_q == ROW_LAST) begin
              row_d   = ROW_LAST;
              off_d   = LAST_ROW_OFF;
              ptr_d   = '0;
              state_d = ST_SCROLL;
            end else begin
              row_d       = row_q + 1'b1;
              off_d       = off_q - ADDR_W'(col_q) + ROW_STRIDE;
              out_valid_d = 1'b1;
            end
          end
        end
      end

      // The read data of the requested cell is now registered.
      ST_READ: begin
        cell_d      = rdata_q;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end

      // Copy each cell one row up: read ahead, write the previous read.
      ST_SCROLL: begin
        if (ptr_q < SCROLL_END) begin
          mem_raddr = ptr_q + ROW_STRIDE;
        end
        if (ptr_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q - 1'b1;
          mem_wdata = rdata_q;
        end
        if (ptr_q == SCROLL_END) begin
          state_d = ST_FILL;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // Blank from the pointer to the end of the store.
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = blank;
        if (ptr_q == CELL_LAST) begin
          ptr_d       = '0;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result beat straight from the cursor and cell registers.
  assign out_valid_o              = out_valid_q;
  assign out_data_o.cur_row       = row_q;
  assign out_data_o.cur_col       = col_q;
  assign out_data_o.cursor_offset = OFF_W'(off_q);
  assign out_data_o.cell_value    = cell_q;

  // An accepted command leaves the sequencer busy or a report pending.
  `TCCS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_acc, (state_q != ST_IDLE) || out_valid_q)
  // A report is only offered while the sequencer rests.
  `TCCS_ASSERT_SAME(a_report_idle, clk_i, rst_ni, out_valid_q, state_q == ST_IDLE)
  // The cursor stays on the screen.
  `TCCS_ASSERT_SAME(a_cursor_range, clk_i, rst_ni, 1'b1, (int'(row_q) < SCREEN_HEIGHT) && (int'(col_q) < SCREEN_WIDTH))
  // The linear offset tracks the cursor between commands.
  `TCCS_ASSERT_SAME(a_offset_track, clk_i, rst_ni, state_q == ST_IDLE, off_q == ADDR_W'(int'(row_q) * SCREEN_WIDTH + int'(col_q)))

endmodule
